// ===== sv/gtp_pkg.sv =====
// ---------------------------------------------------------------------------
// gtp_pkg: shared definitions for the gyro turn controller
// Field widths, register indexes, status codes and the structs passed
// between the register bank, the control stage and the drive math.
// ---------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

   // payload widths
   localparam int HEAD_W     = 24;   // gyro heading, 1/64 degree
   localparam int TURN_W     = 20;   // requested turn, 1/64 degree
   localparam int TGT_W      = 25;   // latched target heading
   localparam int ERR_W      = 26;   // heading error
   localparam int DER_W      = 27;   // error difference
   localparam int INT_W      = 32;   // integral accumulator
   localparam int GAIN_W     = 24;
   localparam int BAND_W     = 16;
   localparam int LIM_W      = 15;
   localparam int CNT_W      = 16;
   localparam int DRV_W      = 16;
   localparam int IDX_W      = 3;
   localparam int CSR_DATA_W = 24;

   // products carry the unsigned gain as a positive signed operand
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_D_W = GAIN_W + 1 + DER_W;
   localparam int PROD_I_W = GAIN_W + 1 + INT_W;
   localparam int ACC_W    = PROD_I_W + 2;
   localparam int SHIFT    = 16;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_GAIN_P        = 3'd0;
   localparam logic [IDX_W-1:0] CSR_GAIN_I        = 3'd1;
   localparam logic [IDX_W-1:0] CSR_GAIN_D        = 3'd2;
   localparam logic [IDX_W-1:0] CSR_ARRIVE_BAND   = 3'd3;
   localparam logic [IDX_W-1:0] CSR_INTEGRAL_BAND = 3'd4;
   localparam logic [IDX_W-1:0] CSR_MAX_DRIVE     = 3'd5;
   localparam logic [IDX_W-1:0] CSR_TIMEOUT       = 3'd6;

   // register reset values
   localparam logic [BAND_W-1:0] ARRIVE_BAND_RST   = 16'd64;
   localparam logic [BAND_W-1:0] INTEGRAL_BAND_RST = 16'd640;
   localparam logic [LIM_W-1:0]  MAX_DRIVE_RST     = 15'd16384;
   localparam logic [CNT_W-1:0]  TIMEOUT_RST       = 16'd150;

   // operation codes
   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_RUNNING = 3'd0,
      ST_ARRIVED = 3'd1,
      ST_TIMEOUT = 3'd2,
      ST_ABORTED = 3'd3,
      ST_IDLE    = 3'd4
   } status_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [BAND_W-1:0] arrive_band;
      logic [BAND_W-1:0] integral_band;
      logic [LIM_W-1:0]  max_drive;
      logic [CNT_W-1:0]  timeout;
   } csr_type;

   // operands for the drive math; zero on every item that does not run
   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic signed [DER_W-1:0] deriv;
      logic signed [INT_W-1:0] integ;
      status_type              status;
      logic                    done;
   } ctrl_item_type;

endpackage

`default_nettype wire

// ===== sv/gyro_turn_pid.sv =====
// ---------------------------------------------------------------------------
// gyro_turn_pid: turn-to-angle PID controller
// Start items latch a target heading; sample items run one control period
// and return left/right drive with a status code.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one beat per start or sample. tuser carries the operation
//   (start or sample); tdata carries heading, turn angle and the auto flag.
//   rsp channel: exactly one beat per request beat, in order. tdata carries
//   left and right drive, tuser the status code, tlast marks the beat that
//   ends the turn (arrived, timed out or aborted).
//   csr port: write gains, bands, drive limit and timeout while no beat is
//   in flight; a write lands on the clock edge where csr_we is high.
// Timing:
//   A request beat passes the input, operand, product, sum and result
//   registers before it shows on rsp. One beat is taken every cycle
//   unless a stall fills the pipeline: the turn state loop closes in the
//   control stage; products, sum and clamp run in three further stages.
// Reset and stall:
//   Reset clears the turn state and empties the pipeline; registers return
//   to their documented defaults. When rsp_tready is low the result holds
//   and the pipeline keeps filling its empty stages; req_tready drops only
//   once every stage holds a beat.
// ---------------------------------------------------------------------------
`default_nettype none

module gyro_turn_pid (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration
   input  wire logic                               csr_we,
   input  wire logic [gtp_pkg::IDX_W-1:0]          csr_index,
   input  wire logic [gtp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [gtp_pkg::REQ_DATA_W-1:0]     req_tdata,  // heading, turn_angle, in_auto
   input  wire logic                               req_tuser,  // operation
   // result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [gtp_pkg::RSP_DATA_W-1:0]          rsp_tdata,  // left_drive, right_drive
   output logic [2:0]                              rsp_tuser,  // status
   output logic                                    rsp_tlast   // done_res
);

   localparam int HEAD_W = gtp_pkg::HEAD_W;
   localparam int TURN_W = gtp_pkg::TURN_W;
   localparam int DRV_W  = gtp_pkg::DRV_W;

   gtp_pkg::csr_type       csr;
   gtp_pkg::ctrl_item_type item;
   gtp_pkg::status_type    rsp_status;
   logic                   item_valid;
   logic                   item_ready;
   logic signed [DRV_W-1:0] rsp_left;
   logic signed [DRV_W-1:0] rsp_right;

   gtp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   gtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_heading ($signed(req_tdata[HEAD_W-1:0])),
      .in_turn    ($signed(req_tdata[HEAD_W+TURN_W-1:HEAD_W])),
      .in_auto    (req_tdata[HEAD_W+TURN_W]),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   gtp_math u_math (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_left   (rsp_left),
      .out_right  (rsp_right),
      .out_status (rsp_status),
      .out_done   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_right, rsp_left};
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

// ===== sv/gtp_csr.sv =====
// ---------------------------------------------------------------------------
// gtp_csr: configuration register bank
// Write-only registers loaded from the index/data write port.
// ---------------------------------------------------------------------------
`default_nettype none

module gtp_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [gtp_pkg::IDX_W-1:0]       csr_index,
   input  wire logic [gtp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output gtp_pkg::csr_type                     csr
);

   gtp_pkg::csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gain_p        <= '0;
         csr_ff.gain_i        <= '0;
         csr_ff.gain_d        <= '0;
         csr_ff.arrive_band   <= gtp_pkg::ARRIVE_BAND_RST;
         csr_ff.integral_band <= gtp_pkg::INTEGRAL_BAND_RST;
         csr_ff.max_drive     <= gtp_pkg::MAX_DRIVE_RST;
         csr_ff.timeout       <= gtp_pkg::TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            gtp_pkg::CSR_GAIN_P: begin
               csr_ff.gain_p <= csr_wdata;
            end
            gtp_pkg::CSR_GAIN_I: begin
               csr_ff.gain_i <= csr_wdata;
            end
            gtp_pkg::CSR_GAIN_D: begin
               csr_ff.gain_d <= csr_wdata;
            end
            gtp_pkg::CSR_ARRIVE_BAND: begin
               csr_ff.arrive_band <= csr_wdata[gtp_pkg::BAND_W-1:0];
            end
            gtp_pkg::CSR_INTEGRAL_BAND: begin
               csr_ff.integral_band <= csr_wdata[gtp_pkg::BAND_W-1:0];
            end
            gtp_pkg::CSR_MAX_DRIVE: begin
               csr_ff.max_drive <= csr_wdata[gtp_pkg::LIM_W-1:0];
            end
            gtp_pkg::CSR_TIMEOUT: begin
               csr_ff.timeout <= csr_wdata[gtp_pkg::CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

// ===== sv/gtp_ctrl.sv =====
// ---------------------------------------------------------------------------
// gtp_ctrl: turn state and per-sample decisions
// Input register, then one pass that applies the abort, timeout and
// arrival checks, updates target, error history, integral and period
// count, and registers the operands for the drive math.
// ---------------------------------------------------------------------------
`default_nettype none

module gtp_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gtp_pkg::csr_type                   csr,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire logic                               in_op,
   input  wire logic signed [gtp_pkg::HEAD_W-1:0]  in_heading,
   input  wire logic signed [gtp_pkg::TURN_W-1:0]  in_turn,
   input  wire logic                               in_auto,
   output logic                                    item_valid,
   input  wire logic                               item_ready,
   output gtp_pkg::ctrl_item_type                  item
);

   localparam int ERR_W = gtp_pkg::ERR_W;
   localparam int DER_W = gtp_pkg::DER_W;
   localparam int INT_W = gtp_pkg::INT_W;
   localparam int TGT_W = gtp_pkg::TGT_W;
   localparam int CNT_W = gtp_pkg::CNT_W;

   localparam logic signed [INT_W:0] INT_MAX = (INT_W+1)'({1'b0, {(INT_W-1){1'b1}}});
   localparam logic signed [INT_W:0] INT_MIN = (INT_W+1)'({2'b11, {(INT_W-1){1'b0}}});

   // input register
   logic                              s0_v_ff;
   logic                              s0_op_ff;
   logic signed [gtp_pkg::HEAD_W-1:0] s0_head_ff;
   logic signed [gtp_pkg::TURN_W-1:0] s0_turn_ff;
   logic                              s0_auto_ff;

   // operand register
   logic                   s1_v_ff;
   gtp_pkg::ctrl_item_type s1_ff;
   gtp_pkg::ctrl_item_type s1_in;

   // turn state
   logic                    active_ff, active_in;
   logic signed [TGT_W-1:0] target_ff, target_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;
   logic signed [INT_W-1:0] integ_ff, integ_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    s1_open;
   logic                    s0_adv;
   logic signed [ERR_W-1:0] diff;
   logic signed [ERR_W-1:0] err;
   logic [ERR_W-1:0]        err_mag;
   logic signed [DER_W-1:0] deriv;
   logic signed [INT_W:0]   isum;
   logic signed [INT_W-1:0] isat;

   assign s1_open  = !s1_v_ff || item_ready;
   assign s0_adv   = s0_v_ff && s1_open;
   assign in_ready = !s0_v_ff || s1_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (in_ready) begin
         s0_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s0_op_ff   <= in_op;
         s0_head_ff <= in_heading;
         s0_turn_ff <= in_turn;
         s0_auto_ff <= in_auto;
      end
   end

   always_comb begin
      diff    = ERR_W'(s0_head_ff) - ERR_W'(target_ff);
      err     = -diff;
      err_mag = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
      deriv   = (prev_err_ff == '0) ? '0 : DER_W'(prev_err_ff) - DER_W'(err);
      isum    = (INT_W+1)'(integ_ff) + (INT_W+1)'(err);
      if (isum > INT_MAX) begin
         isat = INT_MAX[INT_W-1:0];
      end else if (isum < INT_MIN) begin
         isat = INT_MIN[INT_W-1:0];
      end else begin
         isat = isum[INT_W-1:0];
      end
   end

   always_comb begin
      active_in    = active_ff;
      target_in    = target_ff;
      prev_err_in  = prev_err_ff;
      integ_in     = integ_ff;
      count_in     = count_ff;
      s1_in.err    = '0;
      s1_in.deriv  = '0;
      s1_in.integ  = '0;
      s1_in.status = gtp_pkg::ST_IDLE;
      s1_in.done   = 1'b0;
      if (s0_op_ff == gtp_pkg::OP_START) begin
         target_in = TGT_W'(s0_head_ff) + TGT_W'(s0_turn_ff);
         count_in  = '0;
         active_in = 1'b1;
      end else if (!active_ff) begin
         // idle sample: nothing moves
      end else if (!s0_auto_ff) begin
         active_in    = 1'b0;
         s1_in.status = gtp_pkg::ST_ABORTED;
         s1_in.done   = 1'b1;
      end else if (count_ff >= csr.timeout) begin
         active_in    = 1'b0;
         s1_in.status = gtp_pkg::ST_TIMEOUT;
         s1_in.done   = 1'b1;
      end else if (err_mag <= ERR_W'(csr.arrive_band)) begin
         active_in    = 1'b0;
         s1_in.status = gtp_pkg::ST_ARRIVED;
         s1_in.done   = 1'b1;
      end else begin
         prev_err_in  = err;
         integ_in     = (err_mag <= ERR_W'(csr.integral_band)) ? isat : '0;
         count_in     = (count_ff == '1) ? count_ff : count_ff + 1'b1;
         s1_in.err    = err;
         s1_in.deriv  = deriv;
         s1_in.integ  = integ_in;
         s1_in.status = gtp_pkg::ST_RUNNING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         target_ff   <= '0;
         prev_err_ff <= '0;
         integ_ff    <= '0;
         count_ff    <= '0;
         s1_v_ff     <= 1'b0;
      end else begin
         if (s0_adv) begin
            active_ff   <= active_in;
            target_ff   <= target_in;
            prev_err_ff <= prev_err_in;
            integ_ff    <= integ_in;
            count_ff    <= count_in;
         end
         if (s1_open) begin
            s1_v_ff <= s0_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_adv) begin
         s1_ff <= s1_in;
      end
   end

   assign item_valid = s1_v_ff;
   assign item       = s1_ff;

endmodule

`default_nettype wire

// ===== sv/gtp_math.sv =====
// ---------------------------------------------------------------------------
// gtp_math: PID drive pipeline
// Three parallel gain products, a registered sum, then the floor shift
// and the symmetric clamp into the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gtp_math (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gtp_pkg::csr_type                  csr,
   input  wire logic                              item_valid,
   output logic                                   item_ready,
   input  wire gtp_pkg::ctrl_item_type            item,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [gtp_pkg::DRV_W-1:0]       out_left,
   output logic signed [gtp_pkg::DRV_W-1:0]       out_right,
   output gtp_pkg::status_type                    out_status,
   output logic                                   out_done
);

   localparam int PROD_P_W = gtp_pkg::PROD_P_W;
   localparam int PROD_D_W = gtp_pkg::PROD_D_W;
   localparam int PROD_I_W = gtp_pkg::PROD_I_W;
   localparam int ACC_W    = gtp_pkg::ACC_W;
   localparam int SHIFT    = gtp_pkg::SHIFT;
   localparam int DRV_W    = gtp_pkg::DRV_W;
   localparam int FULL_W   = ACC_W - SHIFT;

   logic                       en2, en3, en4;
   logic                       v2_ff, v3_ff, v4_ff;

   logic signed [PROD_P_W-1:0] prod_p_in, prod_p_ff;
   logic signed [PROD_D_W-1:0] prod_d_in, prod_d_ff;
   logic signed [PROD_I_W-1:0] prod_i_in, prod_i_ff;
   gtp_pkg::status_type        st2_ff, st3_ff, st4_ff;
   logic                       done2_ff, done3_ff, done4_ff;

   logic signed [ACC_W-1:0]    acc_in, acc_ff;

   logic signed [FULL_W-1:0]   drv;
   logic signed [FULL_W-1:0]   lim;
   logic signed [DRV_W-1:0]    left_in, left_ff;

   assign en4        = !v4_ff || out_ready;
   assign en3        = !v3_ff || en4;
   assign en2        = !v2_ff || en3;
   assign item_ready = en2;

   always_comb begin
      prod_p_in = $signed({1'b0, csr.gain_p}) * item.err;
      prod_d_in = $signed({1'b0, csr.gain_d}) * item.deriv;
      prod_i_in = $signed({1'b0, csr.gain_i}) * item.integ;
   end

   assign acc_in = ACC_W'(prod_p_ff) - ACC_W'(prod_d_ff) + ACC_W'(prod_i_ff);

   // arithmetic shift gives the floor of acc / 2^16
   always_comb begin
      drv = acc_ff[ACC_W-1:SHIFT];
      lim = FULL_W'($signed({1'b0, csr.max_drive}));
      if (drv > lim) begin
         left_in = DRV_W'(lim);
      end else if (drv < -lim) begin
         left_in = DRV_W'(-lim);
      end else begin
         left_in = DRV_W'(drv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en2) begin
            v2_ff <= item_valid;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         prod_p_ff <= prod_p_in;
         prod_d_ff <= prod_d_in;
         prod_i_ff <= prod_i_in;
         st2_ff    <= item.status;
         done2_ff  <= item.done;
      end
      if (en3) begin
         acc_ff   <= acc_in;
         st3_ff   <= st2_ff;
         done3_ff <= done2_ff;
      end
      if (en4) begin
         left_ff  <= left_in;
         st4_ff   <= st3_ff;
         done4_ff <= done3_ff;
      end
   end

   assign out_valid  = v4_ff;
   assign out_left   = left_ff;
   assign out_right  = -left_ff;
   assign out_status = st4_ff;
   assign out_done   = done4_ff;

endmodule

`default_nettype wire

// ===== sv/gtp_checker.sv =====
// ---------------------------------------------------------------------------
// gtp_checker: port-level checks for the gyro turn controller
// Watches the result stream for stall holds, drive symmetry, end-of-turn
// beats and reset behavior; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module gtp_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [gtp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [2:0]                      rsp_tuser,
   input wire logic                            rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_rsp_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] == 16'(-rsp_tdata[15:0]))
      else $error("right drive is not the negated left drive");

   // a beat that ends the turn, or an idle/start beat, carries no drive
   a_end_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tlast || rsp_tuser == gtp_pkg::ST_IDLE) |->
         rsp_tdata[15:0] == 16'd0)
      else $error("drive on a beat that is not running");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tuser == gtp_pkg::ST_ARRIVED ||
                                   rsp_tuser == gtp_pkg::ST_TIMEOUT ||
                                   rsp_tuser == gtp_pkg::ST_ABORTED))
      else $error("tlast does not match the status code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind gyro_turn_pid gtp_checker u_gtp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
